// File: src/dqe_pkg.sv
// ----------------------------------------------------------------------------
// dqe_pkg - shared types and constants of the double-ended queue
// Word types of both channels, command and status codes, control group
// handed from the top level to every cell of the chain.
// ----------------------------------------------------------------------------
package dqe_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// command codes
	localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
	localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
	localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
	localparam logic [1:0] CMD_POP_BACK   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] push_value;
	} cmd_word_t;

	typedef struct packed {
		logic signed [31:0] pop_value;
		logic [1:0]         status;
		logic [4:0]         occupancy;
	} res_word_t;

	// one accepted, successful operation, shared by all cells
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
	} cell_ctl_t;

endpackage

// File: src/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top - double-ended queue of signed words
// A chain of cells keeps the words in order from the front; a fill count
// marks the back. Each command word gives one result word.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+------------------------------
//  cmd     | in        | cmd_valid / cmd_stall | command, push_value
//  res     | out       | res_valid / res_stall | pop_value, status, occupancy
//
//  One command per cycle while cmd_stall is low. When a command is taken, the
//  chain and the fill count update at that edge, and its result word sits in
//  the output register from the next cycle on.
//  cmd_stall is raised only while a result word waits and res_stall is high,
//  so a new command is taken in the same cycle that the old result leaves.
//  Reset clears the fill count and the output valid; the cells hold
//  whatever they held, and only cells below the fill count are ever read.
//  Front pops read cell 0; back pops OR the tail outputs of all cells,
//  of which only the cell just below the fill count is non-zero.
//
module double_ended_queue_top import dqe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd_word,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_word
);

	cnt_t      count_q;
	logic      res_valid_q;
	res_word_t res_word_q;

	word_t     cell_word [DEPTH];
	word_t     tail_word [DEPTH];

	logic      take;
	logic      is_push;
	logic      full;
	logic      empty;
	logic      ok;
	cell_ctl_t ctl;
	logic      pop_back;
	word_t     new_word;
	word_t     back_word;
	word_t     popped;
	cnt_t      count_d;
	res_word_t result;

	// the command side waits only on a stalled, waiting result
	assign cmd_stall = res_valid_q && res_stall;
	assign take      = cmd_valid && !cmd_stall;

	assign is_push  = !cmd_word.command[1];
	assign full     = (count_q == cnt_t'(DEPTH));
	assign empty    = (count_q == '0);
	assign ok       = is_push ? !full : !empty;
	assign new_word = word_t'(cmd_word.push_value);

	always_comb begin
		ctl.push_front = take && ok && (cmd_word.command == CMD_PUSH_FRONT);
		ctl.push_back  = take && ok && (cmd_word.command == CMD_PUSH_BACK);
		ctl.pop_front  = take && ok && (cmd_word.command == CMD_POP_FRONT);
	end
	assign pop_back = take && ok && (cmd_word.command == CMD_POP_BACK);

	// the chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_word;
		word_t right_word;

		if (i == 0) begin : g_head
			assign left_word = new_word;
		end else begin : g_mid_l
			assign left_word = cell_word[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_word = '0;
		end else begin : g_mid_r
			assign right_word = cell_word[i+1];
		end

		dqe_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.free_here  (count_q == cnt_t'(i)),
			.tail_here  (count_q == cnt_t'(i + 1)),
			.new_word   (new_word),
			.left_word  (left_word),
			.right_word (right_word),
			.word       (cell_word[i]),
			.tail_word  (tail_word[i])
		);
	end

	// back word: only the tail cell drives non-zero
	always_comb begin
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_word = back_word | tail_word[i];
		end
	end

	always_comb begin
		popped = '0;
		if (ctl.pop_front) begin
			popped = cell_word[0];
		end else if (pop_back) begin
			popped = back_word;
		end
	end

	always_comb begin
		count_d = count_q;
		if (ctl.push_front || ctl.push_back) begin
			count_d = count_q + cnt_t'(1);
		end else if (ctl.pop_front || pop_back) begin
			count_d = count_q - cnt_t'(1);
		end
	end

	always_comb begin
		result.pop_value = 32'(signed'(popped));
		result.occupancy = 5'(count_d);
		if (ok) begin
			result.status = ST_OK;
		end else if (is_push) begin
			result.status = ST_FULL;
		end else begin
			result.status = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			res_valid_q <= take || (res_valid_q && res_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_word_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule

// File: src/dqe_cell.sv
// ----------------------------------------------------------------------------
// dqe_cell - one storage cell of the deque chain
// Holds the word at one position counted from the front. Shifts towards
// the back on a front push, towards the front on a front pop, and loads
// the new word when it is the first free position on a back push.
// ----------------------------------------------------------------------------
module dqe_cell import dqe_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      free_here,
	input  logic      tail_here,
	input  word_t     new_word,
	input  word_t     left_word,
	input  word_t     right_word,
	output word_t     word,
	output word_t     tail_word
);

	word_t data_q;

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			data_q <= left_word;
		end else if (ctl.pop_front) begin
			data_q <= right_word;
		end else if (ctl.push_back && free_here) begin
			data_q <= new_word;
		end
	end

	assign word      = data_q;
	assign tail_word = tail_here ? data_q : '0;

endmodule

// File: src/dqe_checker.sv
// ----------------------------------------------------------------------------
// dqe_checker - port-level checks of the double-ended queue
// Watches both channels for consistent status, occupancy and
// handshake behaviour.
// ----------------------------------------------------------------------------
module dqe_checker import dqe_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_stall,
	input cmd_word_t cmd_word,
	input logic      res_valid,
	input logic      res_stall,
	input res_word_t res_word
);

	// a full report means the queue really is full
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_word.status == ST_FULL) |-> res_word.occupancy == 5'(DEPTH))
		else $error("full status with occupancy below depth");

	// an empty report carries no word and an empty queue
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_word.status == ST_EMPTY)
		|-> (res_word.occupancy == 5'd0) && (res_word.pop_value == 32'sd0))
		else $error("empty status with data or occupancy");

	// occupancy never goes past the depth
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_word.occupancy <= 5'(DEPTH))
		else $error("occupancy beyond depth");

	// a stalled result word stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_word))
		else $error("stalled result word changed");

	// a taken command gives a result word next cycle; a pop never reports
	// full and a push never reports empty
	a_take_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall
		|=> res_valid
			&& (res_word.status != ($past(cmd_word.command[1]) ? ST_FULL : ST_EMPTY)))
		else $error("taken command without a matching result word");

endmodule

bind double_ended_queue_top dqe_checker u_dqe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd_word  (cmd_word),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_word  (res_word)
);
